FILE: sv/udiv_pkg.sv
`timescale 1ns / 1ps

package udiv_pkg;

  // Operand width; one cell per bit.
  localparam int unsigned DivW    = 64;
  localparam int unsigned CntW    = $clog2(DivW);
  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 2 * DivW;
  localparam int unsigned OutUsedW = 2 * DivW + 1;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;  // Capture a new operand pair.
    logic step;  // Advance one quotient bit.
    logic take;  // Subtract the divisor in this step.
  } cell_ctl_t;

endpackage

FILE: sv/udiv_cell.sv
`timescale 1ns / 1ps

module udiv_cell (
  input  logic                clk_i,
  input  udiv_pkg::cell_ctl_t ctl_i,
  input  logic                dividend_bit_i,
  input  logic                divisor_bit_i,
  input  logic                rem_in_i,
  input  logic                num_in_i,
  input  logic                borrow_i,
  output logic                rem_o,
  output logic                num_o,
  output logic                borrow_o
);
  import udiv_pkg::*;

  logic rem_q, rem_d;
  logic num_q, num_d;
  logic den_q, den_d;
  logic diff;

  // One bit of the shifted remainder minus one bit of the divisor.
  assign diff     = rem_in_i ^ den_q ^ borrow_i;
  assign borrow_o = (~rem_in_i & den_q) | (~(rem_in_i ^ den_q) & borrow_i);

  // Next state: load an operand bit, or shift and optionally keep the difference.
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    den_d = den_q;
    if (ctl_i.load) begin
      rem_d = 1'b0;
      num_d = dividend_bit_i;
      den_d = divisor_bit_i;
    end else if (ctl_i.step) begin
      rem_d = ctl_i.take ? diff : rem_in_i;
      num_d = num_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rem_o = rem_q;
  assign num_o = num_q;

endmodule

FILE: sv/unsigned_divider_64.sv
`timescale 1ns / 1ps

// 64-bit unsigned divider giving quotient and remainder together.
// Input channel s_axis: one transaction carries a dividend and a divisor.
// Output channel m_axis: one transaction carries the quotient, the remainder
// and a divide-by-zero flag for each input transaction, in order.
// A zero divisor gives quotient 0, remainder equal to the dividend, and the flag set.
// The datapath is a row of 64 one-bit cells that together hold the partial
// remainder, the dividend/quotient shift register and the divisor; the row
// resolves one quotient bit per cycle with a borrow chain through all cells.
// An input transaction loads the row; after the 64 bit steps the result moves
// into the output register, where it becomes valid.
// One item is in the row at a time: a new one is accepted only once it has left.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls, a finished item holds in the row until the output
// register frees up, and s_axis_tready stays low meanwhile.
// Reset clears the sequencer and the output valid flag; no result is pending.
module unsigned_divider_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [63:0] dividend, [127:64] divisor
  input  logic [udiv_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] quotient, [127:64] remainder, [128] div_by_zero, rest zero
  output logic [udiv_pkg::OutDataW-1:0] m_axis_tdata
);
  import udiv_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [CntW-1:0] LastStep = CntW'(DivW - 1);

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dz_q, dz_d;
  logic            out_valid_q, out_valid_d;
  logic [DivW-1:0] out_quot_q, out_quot_d;
  logic [DivW-1:0] out_rem_q, out_rem_d;
  logic            out_dz_q, out_dz_d;

  logic            in_fire;
  logic            out_free;
  logic            out_load;
  cell_ctl_t       ctl;
  logic [DivW-1:0] dividend, divisor;
  logic [DivW-1:0] rem_row, num_row, rem_in_row, num_in_row;
  logic [DivW:0]   borrow_row;

  assign dividend = s_axis_tdata[DivW-1:0];
  assign divisor  = s_axis_tdata[2*DivW-1:DivW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign out_load      = (state_q == StDone) & out_free;

  // A set top remainder bit means the shifted value exceeds 64 bits: always subtract.
  assign ctl.load = in_fire;
  assign ctl.step = (state_q == StRun);
  assign ctl.take = rem_row[DivW-1] | ~borrow_row[DivW];

  // Neighbor wiring: remainder and quotient bits move one cell up per step.
  assign rem_in_row    = {rem_row[DivW-2:0], num_row[DivW-1]};
  assign num_in_row    = {num_row[DivW-2:0], ctl.take};
  assign borrow_row[0] = 1'b0;

  for (genvar i = 0; i < DivW; i++) begin : g_cell
    udiv_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .dividend_bit_i (dividend[i]),
      .divisor_bit_i  (divisor[i]),
      .rem_in_i       (rem_in_row[i]),
      .num_in_i       (num_in_row[i]),
      .borrow_i       (borrow_row[i]),
      .rem_o          (rem_row[i]),
      .num_o          (num_row[i]),
      .borrow_o       (borrow_row[i+1])
    );
  end

  // Sequencer: load, 64 bit steps, then hand off to the output register.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dz_d    = dz_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRun;
          cnt_d   = '0;
          dz_d    = (divisor == '0);
        end
      end
      StRun: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register; a zero divisor overrides the row's quotient.
  always_comb begin
    out_valid_d = out_valid_q;
    out_quot_d  = out_quot_q;
    out_rem_d   = out_rem_q;
    out_dz_d    = out_dz_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_dz_d    = dz_q;
      if (dz_q) begin
        out_quot_d = '0;
        // With a zero divisor every step keeps the shifted value, so the
        // remainder row ends up holding the dividend.
        out_rem_d  = rem_row;
      end else begin
        out_quot_d = num_row;
        out_rem_d  = rem_row;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dz_q       <= dz_d;
    out_quot_q <= out_quot_d;
    out_rem_q  <= out_rem_d;
    out_dz_q   <= out_dz_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutUsedW){1'b0}}, out_dz_q, out_rem_q, out_quot_q};

endmodule

FILE: sv/udiv_checker.sv
`timescale 1ns / 1ps

module udiv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [udiv_pkg::OutDataW-1:0] m_axis_tdata
);
  import udiv_pkg::*;

  // The divider takes one item at a time, so it is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("divider accepted a transaction while busy");

  // A new result only appears right after the divider was busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a division in progress");

  // A divide-by-zero result carries a zero quotient.
  a_dz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2*DivW] |-> (m_axis_tdata[DivW-1:0] == '0))
    else $error("divide-by-zero result with nonzero quotient");

  // A stalled result holds its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind unsigned_divider_64 udiv_checker u_udiv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
